// File: sv/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared constants for the first-fit heap allocator: field widths, operation
// codes and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  // parameter defaults
  localparam int unsigned HEAP_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 24;

  // extra bytes a leftover must exceed beyond a header before a split
  localparam int unsigned SPLIT_SLACK = 8;

  // item field widths
  localparam int unsigned OP_W  = 1;
  localparam int unsigned REQ_W = 13;
  localparam int unsigned REL_W = 12;
  localparam int unsigned PAY_W = 12;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

endpackage

`default_nettype wire

// File: sv/ffha_req_if.sv
// ---------------------------------------------------------------------------
// ffha_req_if
// Request channel: valid/ready handshake carrying one allocate or free item.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
  import ffha_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [REQ_W-1:0] request_size;
  logic [REL_W-1:0] release_offset;

  modport source (output valid, output operation, output request_size,
                  output release_offset, input ready);
  modport sink   (input valid, input operation, input request_size,
                  input release_offset, output ready);
endinterface

`default_nettype wire

// File: sv/ffha_rsp_if.sv
// ---------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface ffha_rsp_if;
  import ffha_pkg::*;

  logic             valid;
  logic             ready;
  logic [PAY_W-1:0] payload_offset;
  logic             success;

  modport source (output valid, output payload_offset, output success,
                  input ready);
  modport sink   (input valid, input payload_offset, input success,
                  output ready);
endinterface

`default_nettype wire

// File: sv/first_fit_heap_allocator_core.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with block split and forward coalescing. Block
// headers live in one RAM indexed by header byte offset; a sequencer walks
// them one block per cycle.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                      | item
//  --------+-----+----------------------------------------------+-----------
//  req_ch  | in  | operation, request_size, release_offset      | one request
//  rsp_ch  | out | payload_offset, success                      | one result
//
//  Steps: accept, a walk over the block headers paced by the header RAM read
//  port, write-back and result; a walk visits at most HEAP_BYTES / HEADER_BYTES
//  headers (170 at the defaults); a null free skips the walk.
//  Reset: no clearing pass; entry 0 reads as one free block over the heap
//  until it is first written.
//  Stalls: one request in flight; the next is taken once the result is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ffha_req_if.sink   req_ch,
  ffha_rsp_if.source rsp_ch
);
  import ffha_pkg::*;

  // widths
  localparam int unsigned OFF_W  = $clog2(HEAP_BYTES);
  localparam int unsigned SIZE_W = OFF_W;
  localparam int unsigned ENT_W  = SIZE_W + 1;
  localparam int unsigned CMP_W  = (OFF_W + 2 > REQ_W + 1) ? OFF_W + 2 : REQ_W + 1;

  // constants at arithmetic width
  localparam logic [CMP_W-1:0] HDR_C   = CMP_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0] HEAP_C  = CMP_W'(HEAP_BYTES);
  localparam logic [CMP_W-1:0] SPLIT_C = CMP_W'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [ENT_W-1:0] RST_ENT = {SIZE_W'(HEAP_BYTES - HEADER_BYTES), 1'b1};

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state, state_next;
  logic [OP_W-1:0]   op;
  logic [REQ_W-1:0]  req;
  logic [REL_W-1:0]  rel;
  logic [OFF_W-1:0]  off, off_next;
  logic [SIZE_W-1:0] sz_acc, sz_acc_next;
  logic [PAY_W-1:0]  res_off, res_off_next;
  logic              res_ok, res_ok_next;
  logic              fresh0;
  logic              rd0;
  logic              out_valid;
  logic [PAY_W-1:0]  out_off;
  logic              out_ok;

  // RAM ports
  logic              we;
  logic [OFF_W-1:0]  waddr;
  logic [ENT_W-1:0]  wdata;
  logic [OFF_W-1:0]  raddr;
  logic [ENT_W-1:0]  rdata;
  logic [ENT_W-1:0]  ent;

  // datapath terms
  logic [CMP_W-1:0]  off_c, sz_c, req_c, rel_c, acc_c;
  logic [CMP_W-1:0]  nxt_c, left_c, acc2_c, nxt2_c;
  logic              nxt_ok, nxt2_ok, fits, hit;
  logic              accept;

  ffha_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HEAP_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry 0 holds the reset header until first written
  assign ent = (fresh0 && rd0) ? RST_ENT : rdata;

  assign accept       = req_ch.valid && req_ch.ready;
  assign req_ch.ready = (state == S_IDLE);

  // address and size arithmetic for the header just read
  always_comb begin
    off_c   = CMP_W'(off);
    sz_c    = CMP_W'(ent[ENT_W-1:1]);
    req_c   = CMP_W'(req);
    rel_c   = CMP_W'(rel);
    acc_c   = CMP_W'(sz_acc);
    nxt_c   = off_c + HDR_C + sz_c;
    nxt_ok  = (nxt_c + HDR_C) <= HEAP_C;
    left_c  = sz_c - req_c;
    fits    = ent[0] && (sz_c >= req_c);
    hit     = ((off_c + HDR_C) == rel_c);
    acc2_c  = acc_c + HDR_C + sz_c;
    nxt2_c  = off_c + HDR_C + acc2_c;
    nxt2_ok = (nxt2_c + HDR_C) <= HEAP_C;
  end

  // sequencer
  always_comb begin
    state_next   = state;
    off_next     = off;
    sz_acc_next  = sz_acc;
    res_off_next = res_off;
    res_ok_next  = res_ok;
    we           = 1'b0;
    waddr        = off;
    wdata        = ent;
    raddr        = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          off_next     = '0;
          res_off_next = '0;
          res_ok_next  = 1'b0;
          if (req_ch.operation == OP_FREE && req_ch.release_offset == '0) begin
            res_ok_next = 1'b1;
            state_next  = S_DONE;
          end else begin
            raddr      = '0;
            state_next = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (op == OP_ALLOC && fits) begin
          res_off_next = PAY_W'(off_c + HDR_C);
          res_ok_next  = 1'b1;
          if (left_c > SPLIT_C) begin
            // tail becomes a new free block; own header written next cycle
            we         = 1'b1;
            waddr      = OFF_W'(off_c + HDR_C + req_c);
            wdata      = {SIZE_W'(left_c - HDR_C), 1'b1};
            state_next = S_SPLIT;
          end else begin
            we         = 1'b1;
            wdata      = {ent[ENT_W-1:1], 1'b0};
            state_next = S_DONE;
          end
        end else if (op == OP_FREE && hit) begin
          res_ok_next = 1'b1;
          sz_acc_next = ent[ENT_W-1:1];
          if (nxt_ok) begin
            raddr      = OFF_W'(nxt_c);
            state_next = S_MERGE;
          end else begin
            we         = 1'b1;
            wdata      = {ent[ENT_W-1:1], 1'b1};
            state_next = S_DONE;
          end
        end else if (nxt_ok) begin
          // step to the next block
          off_next = OFF_W'(nxt_c);
          raddr    = OFF_W'(nxt_c);
        end else begin
          state_next = S_DONE;
        end
      end

      S_SPLIT: begin
        we         = 1'b1;
        wdata      = {SIZE_W'(req), 1'b0};
        state_next = S_DONE;
      end

      S_MERGE: begin
        // absorb following free blocks
        if (ent[0]) begin
          sz_acc_next = SIZE_W'(acc2_c);
          if (nxt2_ok) begin
            raddr = OFF_W'(nxt2_c);
          end else begin
            we         = 1'b1;
            wdata      = {SIZE_W'(acc2_c), 1'b1};
            state_next = S_DONE;
          end
        end else begin
          we         = 1'b1;
          wdata      = {sz_acc, 1'b1};
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || rsp_ch.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fresh0    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we && waddr == '0) begin
        fresh0 <= 1'b0;
      end
      if (state == S_DONE && (!out_valid || rsp_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd0     <= (raddr == '0);
    off     <= off_next;
    sz_acc  <= sz_acc_next;
    res_off <= res_off_next;
    res_ok  <= res_ok_next;
    if (accept) begin
      op  <= req_ch.operation;
      req <= req_ch.request_size;
      rel <= req_ch.release_offset;
    end
    if (state == S_DONE && (!out_valid || rsp_ch.ready)) begin
      out_off <= res_off;
      out_ok  <= res_ok;
    end
  end

  assign rsp_ch.valid          = out_valid;
  assign rsp_ch.payload_offset = out_off;
  assign rsp_ch.success        = out_ok;

endmodule

`default_nettype wire

// File: sv/ffha_ram.sv
// ---------------------------------------------------------------------------
// ffha_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: tb/sv/first_fit_heap_allocator_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core_test
// Self-checking bench for the first-fit heap allocator. A directed table walks
// the corner cases: null, unknown and double free, exact fit, the split
// threshold, zero-size allocate and a full heap. Random allocate/free traffic
// follows and is checked against a header-level heap model kept in the
// bench. Both channels idle and stall at random.
// ---------------------------------------------------------------------------

module first_fit_heap_allocator_core_test;
  import ffha_pkg::*;

  localparam int unsigned HEAP          = HEAP_BYTES_DEF;
  localparam int unsigned HDR           = HEADER_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS  = 410;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned DRAIN_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    logic [PAY_W-1:0] offset;
    logic             ok;
  } heap_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] req;
    logic [REL_W-1:0] rel;
    bit               fixed;
    logic [PAY_W-1:0] offset;
    logic             ok;
  } dir_row_t;

  // Corner cases; rows with fixed set carry a reply read straight off the
  // heap layout, the others are checked against the heap model.
  localparam dir_row_t DIRECTED [23] = '{
    '{OP_FREE,  13'd0,    12'd0,    1'b1, 12'd0,    1'b1}, // null free
    '{OP_FREE,  13'd8191, 12'd4095, 1'b1, 12'd0,    1'b0}, // unknown free
    '{OP_ALLOC, 13'd8191, 12'd4095, 1'b1, 12'd0,    1'b0}, // no fit, max field
    '{OP_ALLOC, 13'd4096, 12'd0,    1'b1, 12'd0,    1'b0}, // no fit, whole heap
    '{OP_ALLOC, 13'd4073, 12'd0,    1'b1, 12'd0,    1'b0}, // one byte too many
    '{OP_ALLOC, 13'd4040, 12'd0,    1'b1, 12'd24,   1'b1}, // leftover at limit, no split
    '{OP_ALLOC, 13'd0,    12'd0,    1'b1, 12'd0,    1'b0}, // heap full
    '{OP_FREE,  13'd0,    12'd24,   1'b1, 12'd0,    1'b1},
    '{OP_FREE,  13'd0,    12'd24,   1'b1, 12'd0,    1'b1}, // double free
    '{OP_ALLOC, 13'd4039, 12'd0,    1'b1, 12'd24,   1'b1}, // split, 9-byte tail
    '{OP_ALLOC, 13'd9,    12'd0,    1'b1, 12'd4087, 1'b1}, // tail exact fit
    '{OP_FREE,  13'd0,    12'd4087, 1'b1, 12'd0,    1'b1},
    '{OP_FREE,  13'd0,    12'd24,   1'b1, 12'd0,    1'b1}, // merges tail back
    '{OP_ALLOC, 13'd0,    12'd0,    1'b1, 12'd24,   1'b1}, // zero size, splits
    '{OP_ALLOC, 13'd100,  12'd0,    1'b0, 12'd0,    1'b0},
    '{OP_ALLOC, 13'd0,    12'd0,    1'b0, 12'd0,    1'b0},
    '{OP_ALLOC, 13'd33,   12'd0,    1'b0, 12'd0,    1'b0},
    '{OP_FREE,  13'd0,    12'd48,   1'b0, 12'd0,    1'b0},
    '{OP_FREE,  13'd0,    12'd60,   1'b0, 12'd0,    1'b0}, // inside a payload
    '{OP_FREE,  13'd0,    12'd24,   1'b0, 12'd0,    1'b0}, // forward merge
    '{OP_ALLOC, 13'd130,  12'd0,    1'b0, 12'd0,    1'b0},
    '{OP_FREE,  13'd0,    12'd4095, 1'b0, 12'd0,    1'b0},
    '{OP_ALLOC, 13'd4072, 12'd0,    1'b0, 12'd0,    1'b0}
  };

  logic clk;
  logic rst;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_heap_allocator_core #(
    .HEAP_BYTES  (HEAP),
    .HEADER_BYTES(HDR)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .req_ch(req_if),
    .rsp_ch(rsp_if)
  );

  // heap model: one header per block start offset
  int unsigned hdr_size [HEAP];
  bit          hdr_free [HEAP];

  heap_reply_t allocator_replies [$];
  int unsigned live_offsets [$];
  int unsigned released_offsets [$];

  int          errors        = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the heap model and return the reply it produces.
  function automatic heap_reply_t heap_apply(logic [OP_W-1:0] op, int unsigned req,
                                             int unsigned rel);
    int unsigned off;
    int unsigned sz;
    int unsigned left;
    int unsigned nxt;
    heap_reply_t reply;
    reply = '0;
    off = 0;
    if (op == OP_ALLOC) begin
      // first fit from offset 0
      while (off + HDR <= HEAP) begin
        sz = hdr_size[off];
        if (hdr_free[off] && sz >= req) begin
          left = sz - req;
          if (left > HDR + SPLIT_SLACK) begin
            hdr_size[off + HDR + req] = left - HDR;
            hdr_free[off + HDR + req] = 1'b1;
            sz = req;
          end
          hdr_size[off] = sz;
          hdr_free[off] = 1'b0;
          reply.offset = PAY_W'(off + HDR);
          reply.ok = 1'b1;
          return reply;
        end
        off = off + HDR + sz;
      end
    end else if (rel == 0) begin
      reply.ok = 1'b1;
    end else begin
      // find the block, then absorb free blocks after it
      while (off + HDR <= HEAP) begin
        if (off + HDR == rel) begin
          sz = hdr_size[off];
          nxt = off + HDR + sz;
          while (nxt + HDR <= HEAP && hdr_free[nxt]) begin
            sz = sz + HDR + hdr_size[nxt];
            nxt = off + HDR + sz;
          end
          hdr_size[off] = sz;
          hdr_free[off] = 1'b1;
          reply.ok = 1'b1;
          return reply;
        end
        off = off + HDR + hdr_size[off];
      end
    end
    return reply;
  endfunction

  // Offer one request, wait for it to be taken, then log what it should return.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                           input logic [REL_W-1:0] rel, input bit fixed,
                           input heap_reply_t fixed_reply);
    heap_reply_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= op;
    req_if.request_size   <= req;
    req_if.release_offset <= rel;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    predicted = heap_apply(op, req, rel);
    allocator_replies.push_back(fixed ? fixed_reply : predicted);
    if (op == OP_ALLOC && predicted.ok) live_offsets.push_back(predicted.offset);
  endtask

  // Sender goes quiet until every outstanding reply is back.
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (allocator_replies.size() != 0) @(posedge clk);
  endtask

  // Reply side: check each accepted item, then drive ready.
  always @(posedge clk) begin : reply_monitor
    heap_reply_t exp_reply;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (allocator_replies.size() == 0) begin
        $display("%0t: unexpected reply: payload_offset=%0d success=%0b",
                 $time, rsp_if.payload_offset, rsp_if.success);
        errors++;
      end else begin
        exp_reply = allocator_replies.pop_front();
        if (rsp_if.payload_offset !== exp_reply.offset) begin
          $display("%0t: payload_offset mismatch: expected %0d, actual %0d",
                   $time, exp_reply.offset, rsp_if.payload_offset);
          errors++;
        end
        if (rsp_if.success !== exp_reply.ok) begin
          $display("%0t: success mismatch: expected %0b, actual %0b",
                   $time, exp_reply.ok, rsp_if.success);
          errors++;
        end
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0] op;
    int unsigned req_sz;
    int unsigned rel_off;
    int unsigned idx;
    int unsigned pick;
    int unsigned alloc_pct;
    heap_reply_t fixed_reply;

    req_if.valid          = 1'b0;
    req_if.operation      = OP_ALLOC;
    req_if.request_size   = '0;
    req_if.release_offset = '0;
    rst                   = 1'b1;

    // heap after reset: one free block over everything
    for (int i = 0; i < HEAP; i++) begin
      hdr_size[i] = 0;
      hdr_free[i] = 1'b0;
    end
    hdr_size[0] = HEAP - HDR;
    hdr_free[0] = 1'b1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    foreach (DIRECTED[i]) begin
      fixed_reply.offset = DIRECTED[i].offset;
      fixed_reply.ok     = DIRECTED[i].ok;
      send_item(DIRECTED[i].op, DIRECTED[i].req, DIRECTED[i].rel, DIRECTED[i].fixed,
                fixed_reply);
    end
    drain_replies();

    // random traffic: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
      rcv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (phase == 2 && n == 100) hold_requests <= hold_requests + 1;
        if (phase == 1 && n == 200) drain_replies();

        // lean toward frees when many blocks are live
        alloc_pct = (live_offsets.size() < 10) ? 75 :
                    (live_offsets.size() > 40) ? 25 : 50;
        if ($urandom_range(99) < alloc_pct) begin
          op      = OP_ALLOC;
          rel_off = $urandom_range(4095);
          pick    = $urandom_range(99);
          if (pick < 5)       req_sz = 0;
          else if (pick < 55) req_sz = $urandom_range(64, 1);
          else if (pick < 80) req_sz = $urandom_range(400, 65);
          else if (pick < 93) req_sz = $urandom_range(2000, 401);
          else if (pick < 98) req_sz = $urandom_range(4096, 2001);
          else                req_sz = $urandom_range(8191);
        end else begin
          op     = OP_FREE;
          req_sz = $urandom_range(8191);
          pick   = $urandom_range(99);
          if (pick < 65 && live_offsets.size() != 0) begin
            idx     = $urandom_range(live_offsets.size() - 1);
            rel_off = live_offsets[idx];
            live_offsets.delete(idx);
            released_offsets.push_back(rel_off);
            if (released_offsets.size() > 16) void'(released_offsets.pop_front());
          end else if (pick < 75 && released_offsets.size() != 0) begin
            rel_off = released_offsets[$urandom_range(released_offsets.size() - 1)];
          end else if (pick < 85) begin
            rel_off = 0;
          end else begin
            rel_off = $urandom_range(4095);
          end
        end
        send_item(op, REQ_W'(req_sz), REL_W'(rel_off), 1'b0, '0);
      end
      drain_replies();
    end

    // let any stray reply show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && allocator_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
